// ===== src/bgma_pkg.sv =====
`timescale 1ns / 1ps

package bgma_pkg;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int RATIO_W  = 12;
  localparam int CV_W     = 11;
  localparam int MV_W     = 16;
  localparam int PCT_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Largest ADC reading
  localparam int SAMPLE_MAX = 4095;

  // Default ring depth
  localparam int SAMPLE_COUNT_DEF = 8;

  // Register reset values
  localparam logic [RATIO_W-1:0] RATIO_RST = 12'd512;
  localparam logic [CV_W-1:0]    FULL_RST  = 11'd420;
  localparam logic [CV_W-1:0]    EMPTY_RST = 11'd330;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY = 2'd2;

  // Arithmetic constants
  localparam int MV_PER_CV   = 10;
  localparam int PCT_FULL    = 100;
  localparam logic [MV_W-1:0] MV_MAX = 16'hFFFF;
  // x / 10 == (x * 52429) >> 19 for any 16-bit x
  localparam int CV_RECIP    = 52429;
  localparam int CV_SHIFT    = 19;
  localparam int CVP_W       = 32;
  localparam int CVQ_W       = 13;
  // (cv - empty) * 100 stays below 2^18
  localparam int PNUM_W      = CV_W + PCT_W;
  localparam int Q8_SHIFT    = 8;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio_q8;
    logic [CV_W-1:0]    full_cv;
    logic [CV_W-1:0]    empty_cv;
  } cfg_t;

endpackage

// ===== src/bgma_fifo.sv =====
`timescale 1ns / 1ps

module bgma_fifo import bgma_pkg::*; #(
  parameter int DATA_W = 15
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] rd_data_o,
  output logic              empty_o
);

  logic [DATA_W-1:0] slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign rd_data_o = slot_q[rd_ptr_q];

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue pop while empty");
`endif

endmodule

// ===== src/bgma_front.sv =====
`timescale 1ns / 1ps

module bgma_front import bgma_pkg::*; #(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF,
  parameter int SUM_W        = 15
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] sample_mv_i,
  output logic                push_o,
  output logic [SUM_W-1:0]    sum_o,
  input  logic                full_i
);

  localparam int SLOT_W = $clog2(SAMPLE_COUNT);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SAMPLE_COUNT - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_UPD  = 1'b1;

  logic state_q, state_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic [SUM_W-1:0]        sum_q, sum_d;
  logic [SAMPLE_COUNT-1:0] valid_q, valid_d;
  logic [SAMPLE_W-1:0]     sample_q;
  logic [SAMPLE_W-1:0]     rd_q;
  logic [SAMPLE_W-1:0]     old_mv;
  logic [SUM_W-1:0]        new_sum;
  logic                    accept;
  logic                    commit;

  logic [SAMPLE_W-1:0] ring_mem [SAMPLE_COUNT];

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign commit     = (state_q == S_UPD) && !full_i;

  // Never-written entries read as zero
  assign old_mv  = valid_q[slot_q] ? rd_q : '0;
  assign new_sum = sum_q - SUM_W'(old_mv) + SUM_W'(sample_q);

  assign push_o = commit;
  assign sum_o  = new_sum;

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    sum_d   = sum_q;
    valid_d = valid_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (commit) begin
          sum_d           = new_sum;
          valid_d[slot_q] = 1'b1;
          slot_d          = (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      slot_q  <= '0;
      sum_q   <= '0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      sum_q   <= sum_d;
      valid_q <= valid_d;
    end
  end

  // Sample capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_mv_i;
    end
  end

  // Ring memory: old entry is read while idle, new one written on commit
  always_ff @(posedge clk_i) begin
    if (commit) begin
      ring_mem[slot_q] <= sample_q;
    end
    rd_q <= ring_mem[slot_q];
  end

endmodule

// ===== src/bgma_div.sv =====
`timescale 1ns / 1ps

module bgma_div import bgma_pkg::*; #(
  parameter int NUM_W = 19,
  parameter int DEN_W = 11,
  parameter int IDX_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [IDX_W-1:0] top_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  // Restoring long division, one quotient bit per cycle from bit top_i down.
  // rem_i must already be below den_i.
  logic             busy_q;
  logic             done_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [IDX_W-1:0] idx_q;
  logic [NUM_W-1:0] quot_q;
  logic [DEN_W:0]   trial;
  logic             qbit;
  logic [DEN_W-1:0] rem_nx;

  assign trial  = {rem_q, num_q[idx_q]};
  assign qbit   = (trial >= {1'b0, den_q});
  assign rem_nx = qbit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];

  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q && (idx_q == '0)) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= rem_i;
      idx_q  <= top_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_nx;
      quot_q <= {quot_q[NUM_W-2:0], qbit};
      idx_q  <= idx_q - IDX_W'(1);
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");
`endif

endmodule

// ===== src/bgma_back.sv =====
`timescale 1ns / 1ps

module bgma_back import bgma_pkg::*; #(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF,
  parameter int SUM_W        = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             empty_i,
  input  logic [SUM_W-1:0] sum_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [MV_W-1:0]  battery_mv_o,
  output logic [PCT_W-1:0] percent_o
);

  localparam int PROD_W    = SUM_W + RATIO_W;
  localparam int AVG_W     = PROD_W - Q8_SHIFT;
  // Reciprocal of the ring depth, exact for every AVG_W-bit dividend
  localparam int RCP_SHIFT = AVG_W + $clog2(SAMPLE_COUNT);
  localparam longint RCP_ONE = longint'(1) << RCP_SHIFT;
  localparam longint RCP     = (RCP_ONE + longint'(SAMPLE_COUNT) - 1) / longint'(SAMPLE_COUNT);
  localparam int ARP_W     = AVG_W + RCP_SHIFT;
  localparam int NUM_W     = PNUM_W;
  localparam int DEN_W     = CV_W;
  localparam int IDX_W     = $clog2(NUM_W);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_AVG   = 3'd1;
  localparam logic [2:0] B_CMP   = 3'd2;
  localparam logic [2:0] B_CV    = 3'd3;
  localparam logic [2:0] B_D2GO  = 3'd4;
  localparam logic [2:0] B_D2WT  = 3'd5;
  localparam logic [2:0] B_OUT   = 3'd6;

  logic [2:0]        state_q, state_d;
  logic              out_valid_q, out_valid_d;
  logic [PROD_W-1:0] prod_q;
  logic [MV_W-1:0]   mv_q;
  logic [PCT_W-1:0]  pct_q;
  logic [CVP_W-1:0]  cvp_q;
  logic [PNUM_W-1:0] pnum_q;
  logic [MV_W-1:0]   out_mv_q;
  logic [PCT_W-1:0]  out_pct_q;

  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic [DEN_W-1:0]  div_rem;
  logic [IDX_W-1:0]  div_top;
  logic              div_done;
  logic [NUM_W-1:0]  div_quot;

  logic [ARP_W-1:0]  avg_prod;
  logic [AVG_W-1:0]  avg;
  logic [MV_W-1:0]   full_mv;
  logic [MV_W-1:0]   empty_mv;
  logic [MV_W-1:0]   mv_sat;
  logic [CVQ_W-1:0]  cv;
  logic [CV_W-1:0]   cv_diff;
  logic              out_load;

  // Ring average: drop the Q8 fraction, then multiply by the depth reciprocal
  assign avg_prod = ARP_W'(prod_q >> Q8_SHIFT) * ARP_W'(RCP);
  assign avg      = avg_prod[RCP_SHIFT +: AVG_W];
  assign mv_sat   = (avg > AVG_W'(MV_MAX)) ? MV_MAX : avg[MV_W-1:0];

  assign full_mv  = MV_W'(cfg_i.full_cv) * MV_W'(MV_PER_CV);
  assign empty_mv = MV_W'(cfg_i.empty_cv) * MV_W'(MV_PER_CV);
  assign cv       = cvp_q[CV_SHIFT +: CVQ_W];
  // Below full here, so the difference fits the centivolt width
  assign cv_diff  = CV_W'(cv - CVQ_W'(cfg_i.empty_cv));

  assign pop_o    = (state_q == B_IDLE) && !empty_i;
  assign out_load = (state_q == B_OUT) && (!out_valid_q || out_ready_i);

  // Percent divide operands; quotient stays below 100, so 7 bits are enough
  assign div_start = (state_q == B_D2GO);
  assign div_num   = pnum_q;
  assign div_den   = cfg_i.full_cv - cfg_i.empty_cv;
  assign div_rem   = DEN_W'(pnum_q >> PCT_W);
  assign div_top   = IDX_W'(PCT_W - 1);

  bgma_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .IDX_W (IDX_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .rem_i   (div_rem),
    .top_i   (div_top),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      B_IDLE: if (!empty_i) state_d = B_AVG;
      B_AVG:  state_d = B_CMP;
      B_CMP: begin
        if ((mv_q >= full_mv) || (mv_q <= empty_mv)) begin
          state_d = B_OUT;
        end else begin
          state_d = B_CV;
        end
      end
      B_CV:   state_d = B_D2GO;
      B_D2GO: state_d = B_D2WT;
      B_D2WT: if (div_done) state_d = B_OUT;
      B_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_q <= PROD_W'(sum_i) * PROD_W'(cfg_i.ratio_q8);
    end
    if (state_q == B_AVG) begin
      mv_q <= mv_sat;
    end
    if (state_q == B_CMP) begin
      cvp_q <= CVP_W'(mv_q) * CVP_W'(CV_RECIP);
      if (mv_q >= full_mv) begin
        pct_q <= PCT_W'(PCT_FULL);
      end else begin
        pct_q <= '0;
      end
    end
    if (state_q == B_CV) begin
      pnum_q <= PNUM_W'(cv_diff) * PNUM_W'(PCT_FULL);
    end
    if ((state_q == B_D2WT) && div_done) begin
      pct_q <= div_quot[PCT_W-1:0];
    end
    if (out_load) begin
      out_mv_q  <= mv_q;
      out_pct_q <= pct_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign battery_mv_o = out_mv_q;
  assign percent_o    = out_pct_q;

`ifndef SYNTHESIS
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (percent_o <= PCT_W'(PCT_FULL)))
    else $error("percent above full scale");
`endif

endmodule

// ===== src/battery_gauge_moving_average.sv =====
`timescale 1ns / 1ps
// Result path: ring update, then the back end's average, threshold compare and
// bit-serial percent divide, skipped when the reading is at or beyond a
// threshold; a stalled output adds its stall. The divide sets the throughput;
// new readings are taken while the back end works, until the sum queue is full.
// Reset: ring entries read as zero through per-entry valid bits, sum and slot
// clear, registers take their defaults; no clearing pass is needed.

module battery_gauge_moving_average import bgma_pkg::*; #(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SAMPLE_W-1:0]   sample_mv_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [MV_W-1:0]       battery_mv_o,
  output logic [PCT_W-1:0]      percent_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SUM_W = $clog2(SAMPLE_COUNT * SAMPLE_MAX + 1);

  cfg_t             cfg_q;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  logic [SUM_W-1:0] wr_sum;
  logic [SUM_W-1:0] rd_sum;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ratio_q8 <= RATIO_RST;
      cfg_q.full_cv  <= FULL_RST;
      cfg_q.empty_cv <= EMPTY_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RATIO: cfg_q.ratio_q8 <= cfg_data_i[RATIO_W-1:0];
        CFG_FULL:  cfg_q.full_cv  <= cfg_data_i[CV_W-1:0];
        CFG_EMPTY: cfg_q.empty_cv <= cfg_data_i[CV_W-1:0];
        default: ;
      endcase
    end
  end

  bgma_front #(
    .SAMPLE_COUNT (SAMPLE_COUNT),
    .SUM_W        (SUM_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_mv_i (sample_mv_i),
    .push_o      (push),
    .sum_o       (wr_sum),
    .full_i      (full)
  );

  bgma_fifo #(
    .DATA_W (SUM_W)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data_i (wr_sum),
    .full_o    (full),
    .pop_i     (pop),
    .rd_data_o (rd_sum),
    .empty_o   (empty)
  );

  bgma_back #(
    .SAMPLE_COUNT (SAMPLE_COUNT),
    .SUM_W        (SUM_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .empty_i      (empty),
    .sum_i        (rd_sum),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .battery_mv_o (battery_mv_o),
    .percent_o    (percent_o)
  );

endmodule

// ===== dv/tb_battery_gauge_moving_average.sv =====
`timescale 1ns / 1ps

module tb_battery_gauge_moving_average;
  import bgma_pkg::*;

  localparam int RING_DEPTH = SAMPLE_COUNT_DEF;
  // Index past the register list, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    logic [MV_W-1:0]  mv;
    logic [PCT_W-1:0] pct;
  } gauge_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   sample_mv = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [MV_W-1:0]       battery_mv;
  logic [PCT_W-1:0]      percent;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the gauge: ring, slot, sum and registers
  logic [SAMPLE_W-1:0] shadow_ring [RING_DEPTH];
  int unsigned         shadow_slot = 0;
  int unsigned         shadow_sum = 0;
  logic [RATIO_W-1:0]  shadow_ratio = RATIO_RST;
  logic [CV_W-1:0]     shadow_full = FULL_RST;
  logic [CV_W-1:0]     shadow_empty = EMPTY_RST;

  gauge_t expected_readings_q [$];
  int     fail_count = 0;

  // Idle knobs for the sender and the result monitor, and the phase's sample level
  int sender_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int phase_level = 0;

  battery_gauge_moving_average #(
    .SAMPLE_COUNT(RING_DEPTH)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .sample_mv_i (sample_mv),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .battery_mv_o(battery_mv),
    .percent_o   (percent),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Update the shadow ring with one reading and return the expected beat
  function automatic gauge_t average_and_grade(input logic [SAMPLE_W-1:0] s);
    longint unsigned scaled;
    int unsigned     mv;
    int unsigned     full_cv;
    int unsigned     empty_cv;
    gauge_t          r;
    shadow_sum = shadow_sum - 32'(shadow_ring[shadow_slot]) + 32'(s);
    shadow_ring[shadow_slot] = s;
    shadow_slot = (shadow_slot + 1) % RING_DEPTH;
    scaled = (longint'(shadow_sum) * 64'(shadow_ratio)) / (RING_DEPTH * 256);
    mv = (scaled > 64'(MV_MAX)) ? 32'(MV_MAX) : 32'(scaled);
    full_cv = 32'(shadow_full);
    empty_cv = 32'(shadow_empty);
    r.mv = mv[MV_W-1:0];
    // Full wins over empty, so the divide only runs with full above empty
    if (mv >= full_cv * MV_PER_CV) begin
      r.pct = PCT_W'(PCT_FULL);
    end else if (mv <= empty_cv * MV_PER_CV) begin
      r.pct = '0;
    end else begin
      r.pct = PCT_W'(((mv / MV_PER_CV - empty_cv) * PCT_FULL) / (full_cv - empty_cv));
    end
    return r;
  endfunction

  task automatic check_beat(input logic [MV_W-1:0] mv, input logic [PCT_W-1:0] pct);
    gauge_t want;
    if (expected_readings_q.size() == 0) begin
      $error("unexpected result beat: battery_mv %0d, percent %0d", mv, pct);
      fail_count++;
    end else begin
      want = expected_readings_q.pop_front();
      if (mv !== want.mv) begin
        $error("battery_mv: expected %0d, actual %0d", want.mv, mv);
        fail_count++;
      end
      if (pct !== want.pct) begin
        $error("percent: expected %0d, actual %0d", want.pct, pct);
        fail_count++;
      end
    end
  endtask

  // Result side: checks each beat and drives ready with stalls and holds
  initial begin : result_monitor
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        check_beat(battery_mv, percent);
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one reading; valid stays up on return so beats can go back to back
  task automatic send_reading(input logic [SAMPLE_W-1:0] s);
    if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_mv <= s;
    do @(posedge clk); while (!in_ready);
    expected_readings_q.push_back(average_and_grade(s));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_readings_q.size() != 0);
  endtask

  // Register write; only called with the gauge idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_RATIO: shadow_ratio = d[RATIO_W-1:0];
      CFG_FULL:  shadow_full = d[CV_W-1:0];
      CFG_EMPTY: shadow_empty = d[CV_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Reset values: ratio 2.0 means mv = sum / 4, thresholds 3300 and 4200 mv
  task automatic test_reset_thresholds();
    send_reading(12'd0);
    send_reading(12'd4095);
    send_reading(12'd4095);
    send_reading(12'd4095);
    send_reading(12'd915);   // exactly at empty
    send_reading(12'd1800);  // halfway
    send_reading(12'd1796);  // one mv under full
    send_reading(12'd4);     // exactly at full
    send_reading(12'd4095);  // ring wraps, above full
    wait_drained();
  endtask

  // Full equal to, below, and with both at the top; then full out of range
  task automatic test_degenerate_thresholds();
    write_reg(CFG_EMPTY, 12'd420);
    send_reading(12'd0);
    wait_drained();
    write_reg(CFG_FULL, 12'd100);
    write_reg(CFG_EMPTY, 12'd2000);
    send_reading(12'd0);
    wait_drained();
    write_reg(CFG_FULL, 12'd2000);
    send_reading(12'd0);
    wait_drained();
    write_reg(CFG_FULL, 12'd4095);
    write_reg(CFG_EMPTY, 12'd0);
    send_reading(12'd4095);
    wait_drained();
  endtask

  // Largest ratio with a full ring of max readings, then ratio zero
  task automatic test_ratio_extremes();
    write_reg(CFG_RATIO, 12'd4095);
    repeat (RING_DEPTH) send_reading(12'd4095);
    wait_drained();
    write_reg(CFG_RATIO, 12'd0);
    write_reg(CFG_FULL, 12'd0);
    send_reading(12'd4095);
    wait_drained();
    // Unmapped index leaves every register alone
    write_reg(CFG_UNMAPPED, 12'd256);
    send_reading(12'd4095);
    wait_drained();
  endtask

  // Receiver holds off long enough that the input side backs up
  task automatic test_output_hold();
    write_reg(CFG_RATIO, 12'd512);
    write_reg(CFG_FULL, 12'd420);
    write_reg(CFG_EMPTY, 12'd330);
    sender_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 400;
    repeat (24) send_reading(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
    wait_drained();
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input int level);
    int v;
    case ($urandom_range(0, 19))
      0: v = 0;
      1: v = SAMPLE_MAX;
      2, 3, 4, 5: v = $urandom_range(0, SAMPLE_MAX);
      default: v = level + int'($urandom_range(0, 400)) - 200;
    endcase
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v[SAMPLE_W-1:0];
  endfunction

  // New register set for a phase; thresholds mostly bracket the expected level
  task automatic pick_settings();
    int ratio;
    int center_cv;
    int span;
    int full_cv;
    int empty_cv;
    case ($urandom_range(0, 9))
      0: ratio = 256;
      1: ratio = 4095;
      2: ratio = $urandom_range(0, 255);
      default: ratio = $urandom_range(256, 4095);
    endcase
    phase_level = $urandom_range(0, SAMPLE_MAX);
    center_cv = (phase_level * ratio / 256) / MV_PER_CV;
    span = $urandom_range(1, 300);
    empty_cv = (center_cv - span < 0) ? 0 : center_cv - span;
    full_cv = center_cv + span;
    if (empty_cv > 2000) empty_cv = 2000;
    if (full_cv > 2000) full_cv = 2000;
    case ($urandom_range(0, 9))
      0: begin
        full_cv = $urandom_range(0, 2000);
        empty_cv = full_cv;
      end
      1: begin
        full_cv = $urandom_range(0, 1000);
        empty_cv = $urandom_range(full_cv, 2000);
      end
      2: begin
        full_cv = 2000;
        empty_cv = 0;
      end
      3: begin
        full_cv = $urandom_range(0, 4095);
        empty_cv = $urandom_range(0, 4095);
      end
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) begin
      write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom_range(0, 4095)));
    end
    write_reg(CFG_RATIO, ratio[CFG_DATA_W-1:0]);
    write_reg(CFG_FULL, full_cv[CFG_DATA_W-1:0]);
    write_reg(CFG_EMPTY, empty_cv[CFG_DATA_W-1:0]);
  endtask

  task automatic test_random_settings();
    int n;
    repeat (18) begin
      pick_settings();
      case ($urandom_range(0, 3))
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 10;
        2: sender_idle_pct = 30;
        default: sender_idle_pct = 60;
      endcase
      case ($urandom_range(0, 3))
        0: recv_idle_pct = 0;
        1: recv_idle_pct = 10;
        2: recv_idle_pct = 30;
        default: recv_idle_pct = 60;
      endcase
      n = $urandom_range(80, 120);
      repeat (n) send_reading(pick_sample(phase_level));
      wait_drained();
    end
  endtask

  // Closing stretch at full rate, no idling on either side
  task automatic test_steady_tail();
    pick_settings();
    sender_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (150) send_reading(pick_sample(phase_level));
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < RING_DEPTH; i++) shadow_ring[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_thresholds();
    test_degenerate_thresholds();
    test_ratio_extremes();
    test_output_hold();
    test_random_settings();
    test_steady_tail();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== battery_gauge_moving_average.f =====
src/bgma_pkg.sv
src/bgma_fifo.sv
src/bgma_front.sv
src/bgma_div.sv
src/bgma_back.sv
src/battery_gauge_moving_average.sv
dv/tb_battery_gauge_moving_average.sv
